/* rtl/core/ttdc_pkg.sv */
// shared types, constants and microcode program for the tone timer divisor calculator
package ttdc_pkg;

	localparam int unsigned CLK_W  = 32;
	localparam int unsigned VOL_W  = 16;
	localparam int unsigned FREQ_W = 20;
	localparam int unsigned PSC_W  = 18;
	localparam int unsigned RLD_W  = 16;
	localparam int unsigned CNT_W  = 5;

	localparam logic [PSC_W-1:0] PRESC_START  = 18'd4;
	localparam logic [RLD_W-1:0] RELOAD_LIMIT = 16'd65000;
	localparam logic [RLD_W-1:0] COMPARE_MAX  = 16'hFFFF;

	localparam logic [CLK_W-1:0] RST_CORE_CLOCK = 32'd48000000;
	localparam logic [VOL_W-1:0] RST_VOL_NUM    = 16'd1;
	localparam logic [VOL_W-1:0] RST_VOL_DEN    = 16'd2;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CORE_CLOCK = 2'd0,
		REG_VOL_NUM    = 2'd1,
		REG_VOL_DEN    = 2'd2,
		REG_SILENT     = 2'd3
	} reg_idx_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_LOAD_CLK,
		OP_DIV_STEP,
		OP_SCALE_INIT,
		OP_SCALE_STEP,
		OP_MUL_LOAD,
		OP_CMP_SAT,
		OP_EMIT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NO_REQ,
		COND_FREQ_ZERO,
		COND_CNT_NZ,
		COND_SH_GT,
		COND_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_START = 4'd1;
	localparam step_t STEP_DIV1  = 4'd2;
	localparam step_t STEP_SINIT = 4'd3;
	localparam step_t STEP_SCALE = 4'd4;
	localparam step_t STEP_MUL   = 4'd5;
	localparam step_t STEP_DIV2  = 4'd6;
	localparam step_t STEP_CMP   = 4'd7;
	localparam step_t STEP_EMIT  = 4'd8;
	localparam step_t STEP_END   = 4'd9;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt;
	} ucode_t;

	// jump to tgt when cond holds, else fall through to the next step
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			STEP_IDLE:  w = '{OP_CAPTURE,    COND_NO_REQ,    STEP_IDLE};
			STEP_START: w = '{OP_LOAD_CLK,   COND_FREQ_ZERO, STEP_EMIT};
			STEP_DIV1:  w = '{OP_DIV_STEP,   COND_CNT_NZ,    STEP_DIV1};
			STEP_SINIT: w = '{OP_SCALE_INIT, COND_NONE,      STEP_IDLE};
			STEP_SCALE: w = '{OP_SCALE_STEP, COND_SH_GT,     STEP_SCALE};
			STEP_MUL:   w = '{OP_MUL_LOAD,   COND_NONE,      STEP_IDLE};
			STEP_DIV2:  w = '{OP_DIV_STEP,   COND_CNT_NZ,    STEP_DIV2};
			STEP_CMP:   w = '{OP_CMP_SAT,    COND_NONE,      STEP_IDLE};
			STEP_EMIT:  w = '{OP_EMIT,       COND_OUT_BUSY,  STEP_EMIT};
			STEP_END:   w = '{OP_NOP,        COND_ALWAYS,    STEP_IDLE};
			default:    w = '{OP_NOP,        COND_ALWAYS,    STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/tone_timer_divisor_calc.sv */
// tone timer divisor calculator: microcoded prescaler, reload and duty compare computation
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_stall  | frequency
//  out     | out       | out_valid / out_stall| prescaler, reload, compare, output_enable,
//          |           |                      | bad_frequency
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// each request passes twice through the shared one-bit-per-cycle divide unit, once for the
// reload and once for the compare, with scaling steps for the prescaler doublings (0..15);
// a zero frequency skips the arithmetic and goes straight to the emit step.
// in_stall is low only while the sequencer sits at its idle step; a finished result waits in
// the output register while the next request is accepted and worked on.
// reset (arst_n low) returns the step counter to idle, drops out_valid and loads the
// configuration registers with their reset values.
module tone_timer_divisor_calc
	import ttdc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CLK_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FREQ_W-1:0]   frequency,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PSC_W-1:0]    prescaler,
	output logic [RLD_W-1:0]    reload,
	output logic [RLD_W-1:0]    compare,
	output logic                output_enable,
	output logic                bad_frequency
);

	// configuration
	logic [CLK_W-1:0] core_clock_q;
	logic [VOL_W-1:0] vol_num_q;
	logic [VOL_W-1:0] vol_den_q;
	logic             silent_q;

	// sequencer
	step_t  pc_q;
	step_t  pc_next;
	ucode_t uw;
	logic   jump;

	// datapath
	logic [FREQ_W-1:0] freq_q;
	logic              bad_q;
	logic [CLK_W-1:0]  rem_q;
	logic [CLK_W-1:0]  quo_q;
	logic [CLK_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CLK_W-3:0]  sh_q;
	logic [PSC_W-1:0]  presc_q;
	logic [RLD_W-1:0]  reload_q;
	logic [RLD_W-1:0]  cmp_q;

	// result register
	logic              out_valid_q;
	logic [PSC_W-1:0]  out_presc_q;
	logic [RLD_W-1:0]  out_reload_q;
	logic [RLD_W-1:0]  out_cmp_q;
	logic              out_oe_q;
	logic              out_bad_q;

	logic              out_busy;
	logic              sh_gt;
	logic [CLK_W+1:0]  trial;
	logic              emit_write;

	assign uw       = ucode_rom(pc_q);
	assign in_stall = (pc_q != STEP_IDLE);
	assign out_busy = out_valid_q & out_stall;
	assign sh_gt    = (sh_q > {{(CLK_W-2-RLD_W){1'b0}}, RELOAD_LIMIT});
	// restoring divide step: shifted remainder with next dividend bit minus divisor
	assign trial    = {1'b0, rem_q, quo_q[CLK_W-1]} - {2'b00, div_q};
	assign emit_write = (uw.op == OP_EMIT) && !out_busy;

	always_comb begin
		unique case (uw.cond)
			COND_NONE:      jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_NO_REQ:    jump = !in_valid;
			COND_FREQ_ZERO: jump = (freq_q == '0);
			COND_CNT_NZ:    jump = (cnt_q != '0);
			COND_SH_GT:     jump = sh_gt;
			COND_OUT_BUSY:  jump = out_busy;
			default:        jump = 1'b1;
		endcase
		pc_next = jump ? uw.tgt : step_t'(pc_q + 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= STEP_IDLE;
			out_valid_q  <= 1'b0;
			core_clock_q <= RST_CORE_CLOCK;
			vol_num_q    <= RST_VOL_NUM;
			vol_den_q    <= RST_VOL_DEN;
			silent_q     <= 1'b0;
		end else begin
			pc_q        <= pc_next;
			out_valid_q <= emit_write | out_busy;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_CORE_CLOCK: core_clock_q <= cfg_data;
					REG_VOL_NUM:    vol_num_q    <= cfg_data[VOL_W-1:0];
					REG_VOL_DEN:    vol_den_q    <= cfg_data[VOL_W-1:0];
					REG_SILENT:     silent_q     <= cfg_data[0];
					default:        silent_q     <= silent_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_NOP: begin
				cnt_q <= cnt_q;
			end
			OP_CAPTURE: begin
				if (in_valid) begin
					freq_q <= frequency;
				end
			end
			OP_LOAD_CLK: begin
				bad_q <= (freq_q == '0);
				quo_q <= core_clock_q;
				rem_q <= '0;
				div_q <= {{(CLK_W-FREQ_W){1'b0}}, freq_q};
				cnt_q <= '1;
			end
			OP_DIV_STEP: begin
				if (!trial[CLK_W+1]) begin
					rem_q <= trial[CLK_W-1:0];
				end else begin
					rem_q <= {rem_q[CLK_W-2:0], quo_q[CLK_W-1]};
				end
				quo_q <= {quo_q[CLK_W-2:0], !trial[CLK_W+1]};
				cnt_q <= cnt_q - 5'd1;
			end
			OP_SCALE_INIT: begin
				sh_q    <= quo_q[CLK_W-1:2];
				presc_q <= PRESC_START;
			end
			OP_SCALE_STEP: begin
				if (sh_gt) begin
					sh_q    <= {1'b0, sh_q[CLK_W-3:1]};
					presc_q <= {presc_q[PSC_W-2:0], 1'b0};
				end
			end
			OP_MUL_LOAD: begin
				reload_q <= sh_q[RLD_W-1:0];
				quo_q    <= {{(CLK_W-RLD_W){1'b0}}, sh_q[RLD_W-1:0]}
				          * {{(CLK_W-VOL_W){1'b0}}, vol_num_q};
				rem_q    <= '0;
				div_q    <= {{(CLK_W-VOL_W){1'b0}}, vol_den_q};
				cnt_q    <= '1;
			end
			OP_CMP_SAT: begin
				// zero volume base saturates, as does any quotient that would pass 16 bits
				if (vol_den_q == '0 || quo_q >= {{(CLK_W-RLD_W){1'b0}}, COMPARE_MAX}) begin
					cmp_q <= COMPARE_MAX;
				end else begin
					cmp_q <= quo_q[RLD_W-1:0] + 16'd1;
				end
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_bad_q    <= bad_q;
					out_presc_q  <= bad_q ? '0 : presc_q;
					out_reload_q <= bad_q ? '0 : reload_q;
					out_cmp_q    <= bad_q ? '0 : cmp_q;
					out_oe_q     <= !bad_q && !silent_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign prescaler     = out_presc_q;
	assign reload        = out_reload_q;
	assign compare       = out_cmp_q;
	assign output_enable = out_oe_q;
	assign bad_frequency = out_bad_q;

`ifndef SYNTHESIS
	a_request_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == STEP_START)
		else $error("accepted request did not start the program");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pc_q) == STEP_EMIT)
		else $error("result raised outside the emit step");

	a_presc_power: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_frequency |-> $onehot(prescaler) && prescaler[1:0] == 2'b00)
		else $error("prescaler is not a power of two from 4 up");

	a_reload_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_frequency |-> reload <= RELOAD_LIMIT)
		else $error("reload above limit");

	a_bad_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_frequency |-> prescaler == '0 && reload == '0 && compare == '0
			&& !output_enable)
		else $error("zero frequency result carries values");
`endif

endmodule
